@@ rtl/dtt_pkg.sv @@
// Shared types and constants for the deadline timer table.
`timescale 1ns / 1ps
package dtt_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int SLOT_W = $clog2(TIMER_SLOTS);
	localparam logic [31:0] ROLLBACK_RESET = 32'd3600000;
	localparam logic [1:0] REG_THRESHOLD = 2'd0;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [TIMER_SLOTS-1:0] mask_t;

	typedef enum logic [2:0] {
		FN_ADD     = 3'd0,
		FN_CANCEL  = 3'd1,
		FN_REFRESH = 3'd2,
		FN_RESET   = 3'd3,
		FN_QUERY   = 3'd4,
		FN_EXPIRE  = 3'd5
	} func_t;

	typedef struct packed {
		logic clr;
		logic step;
	} scan_ctl_t;

endpackage

@@ rtl/deadline_timer_table_unit.sv @@
// Top level of the deadline timer table: slot storage, sequencer and ports.
`timescale 1ns / 1ps
// Sixteen timer slots ordered by deadline, ties to the lower slot. Cancel,
// refresh and the reset shortcut finish without a scan. Add, reset and query
// walk all slots through one shared compare unit, one slot a cycle. Expire
// first marks due slots, then runs a full scan plus one output beat per fired
// timer, and ends with a re-arm pass.
// A result beat waits in an output register; the next item is taken while it
// waits, but the block holds further results until that beat is taken.
module deadline_timer_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [3:0]  timer_id,
	input  logic [31:0] period_ms,
	input  logic        recurring,
	input  logic        restart,
	input  logic [63:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  slot_id,
	output logic        ok,
	output logic        is_front,
	output logic [63:0] wait_ms,
	output logic        is_expiry,
	output logic        last,
	output logic        any_active
);
	import dtt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_RST2, ST_SCAN, ST_POST, ST_DUE, ST_REARM
	} state_t;

	typedef struct packed {
		slot_t       slot;
		logic        ok;
		logic        front;
		logic [63:0] waitv;
		logic        exp;
		logic        last;
		logic        any;
	} res_t;

	localparam slot_t SLOT_LAST = slot_t'(TIMER_SLOTS - 1);

	state_t state_q;
	func_t  func_q;
	slot_t  tid_q, target_q, cnt_q;
	logic [31:0] per_q, thr_q;
	logic   rec_q, fn_q, roll_q, front_q, out_valid_q;
	logic [63:0] now_q, last_seen_q, tmp_q;
	mask_t  act_q, recm_q, sel_q, due_q, due_all_q;
	logic [31:0] per_arr [TIMER_SLOTS];
	logic [63:0] dl_arr [TIMER_SLOTS];
	res_t   out_q, res;
	logic   emit, out_free, full;
	slot_t  rd_idx, free_idx, best_idx;
	logic [63:0] rd_dl, add_a, add_b, add_res, best_dl;
	logic [31:0] rd_per;
	logic   rd_act, rd_rec, add_sub, have, due_bit, front_hit;
	mask_t  oh_t, oh_best, due_full, sel_left;
	scan_ctl_t scan_ctl;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_THRESHOLD) ? thr_q : 32'd0;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign rd_idx = (state_q == ST_SCAN || state_q == ST_DUE || state_q == ST_REARM)
		? cnt_q : tid_q;
	assign rd_dl  = dl_arr[rd_idx];
	assign rd_per = per_arr[rd_idx];
	assign rd_act = act_q[rd_idx];
	assign rd_rec = recm_q[rd_idx];

	assign oh_t     = mask_t'(1) << tid_q;
	assign oh_best  = mask_t'(1) << best_idx;
	assign sel_left = sel_q & ~oh_best;
	assign full     = &act_q;
	assign due_bit  = rd_act && (roll_q || rd_dl <= now_q);
	assign due_full = due_q | ({{(TIMER_SLOTS-1){1'b0}}, due_bit} << SLOT_LAST);
	assign front_hit = have && (best_idx == target_q) && !front_q;

	always_comb begin
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!act_q[i]) free_idx = slot_t'(i);
		end
	end

	// shared 64-bit add/subtract
	always_comb begin
		add_a = now_q;
		add_b = {32'd0, per_q};
		add_sub = 1'b0;
		case (state_q)
			ST_EXEC: begin
				case (func_q)
					FN_REFRESH: add_b = {32'd0, rd_per};
					FN_RESET: begin
						add_a = rd_dl;
						add_b = {32'd0, rd_per};
						add_sub = 1'b1;
					end
					FN_EXPIRE: begin
						add_a = last_seen_q;
						add_b = now_q;
						add_sub = 1'b1;
					end
					default: ;
				endcase
			end
			ST_RST2: add_a = tmp_q;
			ST_POST: begin
				add_a = best_dl;
				add_b = now_q;
				add_sub = 1'b1;
			end
			ST_REARM: add_b = {32'd0, rd_per};
			default: ;
		endcase
		add_res = add_a + (add_sub ? ~add_b : add_b) + {63'd0, add_sub};
	end

	// scanner holds its winner while a result waits, restarts after each beat
	always_comb begin
		scan_ctl.step = (state_q == ST_SCAN);
		scan_ctl.clr  = !(state_q == ST_SCAN || (state_q == ST_POST && !out_free));
	end

	dtt_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(scan_ctl),
		.sel_bit(sel_q[cnt_q]),
		.idx(cnt_q),
		.dl_in(rd_dl),
		.have(have),
		.best_idx(best_idx),
		.best_dl(best_dl)
	);

	// result beat selection
	always_comb begin
		emit = 1'b0;
		res = '{slot: tid_q, ok: 1'b0, front: 1'b0, waitv: 64'd0, exp: 1'b0,
			last: 1'b1, any: |act_q};
		case (state_q)
			ST_EXEC: begin
				case (func_q)
					FN_ADD: begin
						emit = out_free && full;
						res.slot = '0;
					end
					FN_CANCEL: begin
						emit = out_free;
						res.ok = rd_act;
						res.any = |(act_q & ~oh_t);
					end
					FN_REFRESH: begin
						emit = out_free;
						res.ok = rd_act;
					end
					FN_RESET: begin
						if (per_q == rd_per && !fn_q) begin
							emit = out_free;
							res.ok = 1'b1;
						end else if (!rd_act) begin
							emit = out_free;
						end
					end
					FN_QUERY: ;
					FN_EXPIRE: begin
						emit = out_free && (act_q == '0);
						res.slot = '0;
					end
					default: begin
						emit = out_free;
						res.slot = '0;
					end
				endcase
			end
			ST_POST: begin
				emit = out_free;
				case (func_q)
					FN_QUERY: begin
						res.slot = have ? best_idx : '0;
						res.ok = have;
						res.waitv = !have ? '1 : (now_q >= best_dl) ? 64'd0 : add_res;
					end
					FN_EXPIRE: begin
						res.slot = best_idx;
						res.ok = 1'b1;
						res.exp = 1'b1;
						res.last = (sel_left == '0);
						res.any = |(act_q & ~(due_all_q & ~recm_q));
					end
					default: begin
						res.slot = target_q;
						res.ok = 1'b1;
						res.front = front_hit;
					end
				endcase
			end
			ST_DUE: begin
				emit = out_free && (cnt_q == SLOT_LAST) && (due_full == '0);
				res.slot = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			act_q <= '0;
			recm_q <= '0;
			front_q <= 1'b0;
			last_seen_q <= '0;
			thr_q <= ROLLBACK_RESET;
			cnt_q <= '0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				per_arr[i] <= '0;
				dl_arr[i] <= '0;
			end
		end else begin
			if (psel && penable && pwrite && paddr == REG_THRESHOLD) thr_q <= pwdata;
			if (emit) begin
				out_valid_q <= 1'b1;
				out_q <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q <= func_t'(func);
						tid_q <= timer_id;
						per_q <= period_ms;
						rec_q <= recurring;
						fn_q <= restart;
						now_q <= now_ms;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						cnt_q <= '0;
						case (func_q)
							FN_ADD: begin
								if (!full) begin
									act_q[free_idx] <= 1'b1;
									recm_q[free_idx] <= rec_q;
									per_arr[free_idx] <= per_q;
									dl_arr[free_idx] <= add_res;
									target_q <= free_idx;
									sel_q <= act_q | (mask_t'(1) << free_idx);
									state_q <= ST_SCAN;
								end
							end
							FN_CANCEL: act_q[tid_q] <= 1'b0;
							FN_REFRESH: if (rd_act) dl_arr[tid_q] <= add_res;
							FN_RESET: begin
								if (!(per_q == rd_per && !fn_q) && rd_act) begin
									tmp_q <= fn_q ? now_q : add_res;
									per_arr[tid_q] <= per_q;
									state_q <= ST_RST2;
								end
							end
							FN_QUERY: begin
								front_q <= 1'b0;
								sel_q <= act_q;
								state_q <= ST_SCAN;
							end
							FN_EXPIRE: begin
								if (act_q != '0) begin
									roll_q <= (now_q < last_seen_q) && (add_res > {32'd0, thr_q});
									last_seen_q <= now_q;
									due_q <= '0;
									state_q <= ST_DUE;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RST2: begin
					dl_arr[tid_q] <= add_res;
					target_q <= tid_q;
					sel_q <= act_q;
					cnt_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SLOT_LAST) state_q <= ST_POST;
				end
				ST_POST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						cnt_q <= '0;
						case (func_q)
							FN_EXPIRE: begin
								sel_q <= sel_left;
								state_q <= (sel_left == '0) ? ST_REARM : ST_SCAN;
							end
							FN_QUERY: ;
							default: if (front_hit) front_q <= 1'b1;
						endcase
					end
				end
				ST_DUE: begin
					if (out_free) begin
						due_q[cnt_q] <= due_bit;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == SLOT_LAST) begin
							due_all_q <= due_full;
							sel_q <= due_full;
							state_q <= (due_full == '0) ? ST_IDLE : ST_SCAN;
						end
					end
				end
				ST_REARM: begin
					if (due_all_q[cnt_q]) begin
						if (rd_rec) dl_arr[cnt_q] <= add_res;
						else act_q[cnt_q] <= 1'b0;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SLOT_LAST) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_id    = out_q.slot;
	assign ok         = out_q.ok;
	assign is_front   = out_q.front;
	assign wait_ms    = out_q.waitv;
	assign is_expiry  = out_q.exp;
	assign last       = out_q.last;
	assign any_active = out_q.any;

`ifndef NO_ASSERTIONS
	a_exp_due: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && out_q.exp |-> out_q.ok && due_all_q[out_q.slot])
		else $error("expiry beat for a slot that was not due");
	a_front_set: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && out_q.front |-> front_q && !out_q.exp)
		else $error("front beat without front notification recorded");
	a_rearm_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POST && func_q == FN_EXPIRE && out_free && sel_left == '0
		|=> state_q == ST_REARM && out_q.last)
		else $error("final expiry beat not followed by re-arm pass");
`endif

endmodule

@@ rtl/dtt_scan.sv @@
// Earliest-deadline scanner: one 64-bit compare per slot per cycle.
`timescale 1ns / 1ps
module dtt_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  dtt_pkg::scan_ctl_t ctl,
	input  logic              sel_bit,
	input  dtt_pkg::slot_t    idx,
	input  logic [63:0]       dl_in,
	output logic              have,
	output dtt_pkg::slot_t    best_idx,
	output logic [63:0]       best_dl
);
	import dtt_pkg::*;

	logic  have_q;
	slot_t best_idx_q;
	logic [63:0] best_dl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clr) begin
			have_q <= 1'b0;
		end else if (ctl.step && sel_bit && (!have_q || dl_in < best_dl_q)) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clr && ctl.step && sel_bit && (!have_q || dl_in < best_dl_q)) begin
			best_idx_q <= idx;
			best_dl_q  <= dl_in;
		end
	end

	assign have     = have_q;
	assign best_idx = best_idx_q;
	assign best_dl  = best_dl_q;

endmodule
